>>> sv/pts_pkg.sv
// shared types and constants for the frame period tracker
// no dependencies; imported by every module of the block
package pts_pkg;

   localparam int TIME_WIDTH = 48;
   localparam int FRAC_BITS  = 8;
   localparam int LOST_WIDTH = 8;

   localparam int PERIOD_W = 17 + FRAC_BITS;
   localparam int DUR_W    = 17;
   localparam int FPS_W    = 8;
   localparam int DIVIDEND_W = TIME_WIDTH + FRAC_BITS;
   localparam int DIVISOR_W  = (LOST_WIDTH + 1 > FPS_W) ? LOST_WIDTH + 1 : FPS_W;
   localparam int DIV_CNT_W  = $clog2(DIVIDEND_W + 1);
   localparam int LOST_CNT_W = $clog2(LOST_WIDTH + 1);

   localparam logic [63:0] US_Q64 = 64'd1000000 << FRAC_BITS;
   localparam logic [DIVIDEND_W-1:0] US_Q = DIVIDEND_W'(US_Q64);
   localparam logic [PERIOD_W-1:0] CEIL_Q = PERIOD_W'((US_Q64 + 64'd7) / 64'd15);
   localparam logic [PERIOD_W-1:0] FLOOR_RESET = PERIOD_W'((US_Q64 + 64'd30) / 64'd60);
   localparam logic [FPS_W-1:0] FPS_DEFAULT = FPS_W'(60);

   typedef struct packed {
      logic [TIME_WIDTH-1:0] arrival_time_us;
      logic [LOST_WIDTH-1:0] lost_count;
   } req_payload_type;

   typedef struct packed {
      logic [TIME_WIDTH-1:0] packet_stamp;
      logic [DUR_W-1:0]      packet_duration_us;
      logic [PERIOD_W-1:0]   period_estimate_q8;
   } rsp_payload_type;

   typedef struct packed {
      logic clear;
      logic start;
      logic advance;
   } stamp_ctrl_type;

endpackage

>>> sv/pts_serial_div.sv
// restoring divider, one quotient bit per cycle
// quotient kept to the period width with a sticky overflow flag; uses pts_pkg
module pts_serial_div (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [pts_pkg::DIVIDEND_W-1:0]  dividend,
   input  logic [pts_pkg::DIVISOR_W-1:0]   divisor,
   output logic                            busy,
   output logic [pts_pkg::PERIOD_W-1:0]    quotient,
   output logic                            overflow
);
   import pts_pkg::*;

   logic [DIV_CNT_W-1:0]  cnt_ff, cnt_in;
   logic [DIVIDEND_W-1:0] num_ff, num_in;
   logic [DIVISOR_W-1:0]  rem_ff, rem_in;
   logic [DIVISOR_W-1:0]  dvs_ff, dvs_in;
   logic [PERIOD_W-1:0]   quot_ff, quot_in;
   logic                  ovf_ff, ovf_in;
   logic [DIVISOR_W:0]    trial;
   logic [DIVISOR_W:0]    trial_sub;
   logic                  ge;

   assign trial     = {rem_ff, num_ff[DIVIDEND_W-1]};
   assign ge        = trial >= {1'b0, dvs_ff};
   assign trial_sub = trial - {1'b0, dvs_ff};

   always_comb begin
      cnt_in  = cnt_ff;
      num_in  = num_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      quot_in = quot_ff;
      ovf_in  = ovf_ff;
      if (start) begin
         cnt_in  = DIV_CNT_W'(DIVIDEND_W);
         num_in  = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
         quot_in = '0;
         ovf_in  = 1'b0;
      end else if (cnt_ff != '0) begin
         cnt_in  = cnt_ff - 1'b1;
         num_in  = {num_ff[DIVIDEND_W-2:0], 1'b0};
         // remainder stays below the divisor, so it fits the divisor width
         rem_in  = ge ? trial_sub[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
         quot_in = {quot_ff[PERIOD_W-2:0], ge};
         ovf_in  = ovf_ff | quot_ff[PERIOD_W-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      num_ff  <= num_in;
      rem_ff  <= rem_in;
      dvs_ff  <= dvs_in;
      quot_ff <= quot_in;
      ovf_ff  <= ovf_in;
   end

   assign busy     = cnt_ff != '0;
   assign quotient = quot_ff;
   assign overflow = ovf_ff;

endmodule

>>> sv/pts_stamp_acc.sv
// synthetic stamp register with a bit-serial skip over lost frames
// adds duration times lost count one lost bit per cycle; uses pts_pkg
module pts_stamp_acc (
   input  logic                            clock,
   input  logic                            reset,
   input  pts_pkg::stamp_ctrl_type         ctrl,
   input  logic [pts_pkg::DUR_W-1:0]       dur,
   input  logic [pts_pkg::LOST_WIDTH-1:0]  lost,
   output logic                            busy,
   output logic [pts_pkg::TIME_WIDTH-1:0]  stamp
);
   import pts_pkg::*;

   logic [TIME_WIDTH-1:0] stamp_ff, stamp_in;
   logic [TIME_WIDTH-1:0] addend_ff, addend_in;
   logic [LOST_WIDTH-1:0] lost_ff, lost_in;
   logic [DUR_W-1:0]      dur_ff, dur_in;
   logic [LOST_CNT_W-1:0] cnt_ff, cnt_in;

   always_comb begin
      stamp_in  = stamp_ff;
      addend_in = addend_ff;
      lost_in   = lost_ff;
      dur_in    = dur_ff;
      cnt_in    = cnt_ff;
      if (ctrl.clear) begin
         stamp_in = '0;
         cnt_in   = '0;
      end else if (ctrl.start) begin
         addend_in = TIME_WIDTH'(dur);
         lost_in   = lost;
         dur_in    = dur;
         cnt_in    = LOST_CNT_W'(LOST_WIDTH);
      end else if (cnt_ff != '0) begin
         if (lost_ff[0]) begin
            stamp_in = stamp_ff + addend_ff;
         end
         addend_in = {addend_ff[TIME_WIDTH-2:0], 1'b0};
         lost_in   = lost_ff >> 1;
         cnt_in    = cnt_ff - 1'b1;
      end else if (ctrl.advance) begin
         stamp_in = stamp_ff + TIME_WIDTH'(dur_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stamp_ff <= '0;
         cnt_ff   <= '0;
      end else begin
         stamp_ff <= stamp_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      addend_ff <= addend_in;
      lost_ff   <= lost_in;
      dur_ff    <= dur_in;
   end

   assign busy  = cnt_ff != '0;
   assign stamp = stamp_ff;

endmodule

>>> sv/frame_period_tracker_pts.sv
// top level of the frame period tracker: control sequence and period filter
// uses pts_pkg, pts_serial_div and pts_stamp_acc
//
// req channel: one item per arriving video packet (arrival time, lost count).
// rsp channel: one item back per packet (stamp, rounded duration, period Q17.8).
// csr channel: write of max_fps; it restarts all tracking state and then
// recomputes the minimum period with the divider; no packet is taken meanwhile.
// work per packet: the gap over delivered frames runs through a restoring
// divider one quotient bit a cycle, then two compare states (ST_CMP1, ST_CMP2),
// then the lost-frame skip one lost bit a cycle; the first packet after reset,
// which has no gap, goes straight to the lost-frame skip.
// one packet is in work at a time; the next is taken back in ST_IDLE once the
// result is registered, even while rsp_valid waits on rsp_ready.
// a stalled receiver holds the result; a following packet finishes its work
// and then waits until the earlier result is taken.
// reset: period at the 60 fps floor, stamp zero, max_fps 60, no packet seen.
module frame_period_tracker_pts (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  pts_pkg::req_payload_type  req_payload,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output pts_pkg::rsp_payload_type  rsp_payload,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [pts_pkg::FPS_W-1:0] csr_data
);
   import pts_pkg::*;

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_FLOOR = 3'd1;
   localparam logic [2:0] ST_DIV   = 3'd2;
   localparam logic [2:0] ST_CMP1  = 3'd3;
   localparam logic [2:0] ST_CMP2  = 3'd4;
   localparam logic [2:0] ST_DUR   = 3'd5;
   localparam logic [2:0] ST_MUL   = 3'd6;
   localparam logic [2:0] ST_DONE  = 3'd7;

   logic [2:0]            state_ff, state_in;
   logic [TIME_WIDTH-1:0] prev_ff, prev_in;
   logic                  seen_ff, seen_in;
   logic [PERIOD_W-1:0]   cur_ff, cur_in;
   logic [PERIOD_W-1:0]   cand_ff, cand_in;
   logic [1:0]            hits_ff, hits_in;
   logic [PERIOD_W-1:0]   lo_ff, lo_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [LOST_WIDTH-1:0] lost_ff, lost_in;
   logic [PERIOD_W-1:0]   obs_ff, obs_in;
   logic [PERIOD_W-1:0]   dcur_ff, dcur_in;
   logic [PERIOD_W-1:0]   dcand_ff, dcand_in;
   rsp_payload_type       rsp_ff, rsp_in;

   logic                  req_fire, csr_fire;
   logic [TIME_WIDTH-1:0] gap;
   logic [FPS_W-1:0]      fps_eff;
   logic                  div_start, div_busy, div_ovf;
   logic [DIVIDEND_W-1:0] div_dividend;
   logic [DIVISOR_W-1:0]  div_divisor;
   logic [PERIOD_W-1:0]   div_quot;
   logic [PERIOD_W-1:0]   quot_sat;
   logic [PERIOD_W+2:0]   five_dcur;
   logic [PERIOD_W+3:0]   ten_dcand;
   logic                  big_change, cand_match;
   logic [1:0]            hits_next;
   logic [PERIOD_W-1:0]   cand_next;
   logic [PERIOD_W:0]     round_sum;
   logic [DUR_W-1:0]      dur_raw, dur_w;
   stamp_ctrl_type        stamp_ctrl;
   logic                  stamp_busy;
   logic [TIME_WIDTH-1:0] stamp;

   assign req_ready = (state_ff == ST_IDLE) && !csr_valid;
   assign csr_ready = state_ff == ST_IDLE;
   assign req_fire  = req_valid && req_ready;
   assign csr_fire  = csr_valid && csr_ready;

   // time going backwards gives a zero gap
   assign gap = (req_payload.arrival_time_us >= prev_ff)
              ? req_payload.arrival_time_us - prev_ff : '0;

   assign fps_eff = (csr_data == '0) ? FPS_DEFAULT : csr_data;

   always_comb begin
      div_start    = csr_fire || (req_fire && seen_ff);
      div_dividend = {gap, {FRAC_BITS{1'b0}}};
      div_divisor  = DIVISOR_W'(req_payload.lost_count) + 1'b1;
      if (csr_fire) begin
         div_dividend = US_Q + DIVIDEND_W'(fps_eff >> 1);
         div_divisor  = DIVISOR_W'(fps_eff);
      end
   end

   pts_serial_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .busy     (div_busy),
      .quotient (div_quot),
      .overflow (div_ovf)
   );

   assign quot_sat = (div_ovf || div_quot > CEIL_Q) ? CEIL_Q : div_quot;

   // 20 percent and 10 percent tests as shift-add multiples
   assign five_dcur  = ((PERIOD_W+3)'(dcur_ff) << 2) + (PERIOD_W+3)'(dcur_ff);
   assign ten_dcand  = ((PERIOD_W+4)'(dcand_ff) << 3) + ((PERIOD_W+4)'(dcand_ff) << 1);
   assign big_change = five_dcur >= (PERIOD_W+3)'(cur_ff);
   assign cand_match = (cand_ff != '0) && (ten_dcand <= (PERIOD_W+4)'(cand_ff));
   assign hits_next  = cand_match ? hits_ff + 2'd1 : 2'd1;
   assign cand_next  = cand_match ? cand_ff : obs_ff;

   assign round_sum = (PERIOD_W+1)'(cur_ff) + (PERIOD_W+1)'(1 << (FRAC_BITS - 1));
   assign dur_raw   = round_sum[FRAC_BITS +: DUR_W];
   assign dur_w     = (dur_raw == '0) ? DUR_W'(1) : dur_raw;

   always_comb begin
      stamp_ctrl.clear   = csr_fire;
      stamp_ctrl.start   = state_ff == ST_DUR;
      stamp_ctrl.advance = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_ready);
   end

   pts_stamp_acc u_stamp (
      .clock (clock),
      .reset (reset),
      .ctrl  (stamp_ctrl),
      .dur   (dur_w),
      .lost  (lost_ff),
      .busy  (stamp_busy),
      .stamp (stamp)
   );

   always_comb begin
      state_in     = state_ff;
      prev_in      = prev_ff;
      seen_in      = seen_ff;
      cur_in       = cur_ff;
      cand_in      = cand_ff;
      hits_in      = hits_ff;
      lo_in        = lo_ff;
      rsp_valid_in = rsp_valid_ff;
      lost_in      = lost_ff;
      obs_in       = obs_ff;
      dcur_in      = dcur_ff;
      dcand_in     = dcand_ff;
      rsp_in       = rsp_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      unique case (state_ff)
         ST_IDLE: begin
            if (csr_fire) begin
               prev_in  = '0;
               seen_in  = 1'b0;
               hits_in  = '0;
               state_in = ST_FLOOR;
            end else if (req_fire) begin
               prev_in  = req_payload.arrival_time_us;
               seen_in  = 1'b1;
               lost_in  = req_payload.lost_count;
               state_in = seen_ff ? ST_DIV : ST_DUR;
            end
         end
         ST_FLOOR: begin
            if (!div_busy) begin
               lo_in    = quot_sat;
               cur_in   = quot_sat;
               cand_in  = quot_sat;
               state_in = ST_IDLE;
            end
         end
         ST_DIV: begin
            if (!div_busy) begin
               obs_in   = (quot_sat < lo_ff) ? lo_ff : quot_sat;
               state_in = ST_CMP1;
            end
         end
         ST_CMP1: begin
            dcur_in  = (obs_ff >= cur_ff) ? obs_ff - cur_ff : cur_ff - obs_ff;
            dcand_in = (obs_ff >= cand_ff) ? obs_ff - cand_ff : cand_ff - obs_ff;
            state_in = ST_CMP2;
         end
         ST_CMP2: begin
            if (big_change) begin
               if (hits_next == 2'd3) begin
                  cur_in  = cand_next;
                  hits_in = '0;
               end else begin
                  hits_in = hits_next;
               end
               cand_in = cand_next;
            end else begin
               cand_in = cur_ff;
               hits_in = '0;
            end
            state_in = ST_DUR;
         end
         ST_DUR: begin
            state_in = ST_MUL;
         end
         ST_MUL: begin
            if (!stamp_busy) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            // wait here while an earlier result is still held
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_in.packet_stamp       = stamp;
               rsp_in.packet_duration_us = dur_w;
               rsp_in.period_estimate_q8 = cur_ff;
               rsp_valid_in              = 1'b1;
               state_in                  = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         prev_ff      <= '0;
         seen_ff      <= 1'b0;
         cur_ff       <= FLOOR_RESET;
         cand_ff      <= FLOOR_RESET;
         hits_ff      <= '0;
         lo_ff        <= FLOOR_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         prev_ff      <= prev_in;
         seen_ff      <= seen_in;
         cur_ff       <= cur_in;
         cand_ff      <= cand_in;
         hits_ff      <= hits_in;
         lo_ff        <= lo_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      lost_ff  <= lost_in;
      obs_ff   <= obs_in;
      dcur_ff  <= dcur_in;
      dcand_ff <= dcand_in;
      rsp_ff   <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule
